// File: sv/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// No dependencies; every other file of the block imports this package.
package u2u_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 4;

  // Lead byte class boundaries.
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] CONT_MAX  = 8'hBF;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;
  localparam logic [7:0] LEAD4_MAX = 8'hF7;

  localparam logic [20:0] SURR_LOW   = 21'h00D800;
  localparam logic [20:0] SURR_HIGH  = 21'h00DFFF;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;
  localparam logic [20:0] BMP_MAX    = 21'h00FFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h010000;
  localparam logic [15:0] HIGH_BASE  = 16'hD800;
  localparam logic [15:0] LOW_BASE   = 16'hDC00;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_UNIT      = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_END_ONLY  = 2'd2
  } status_t;

  // One queue entry: either one result, or a surrogate pair that the back end
  // delivers as two results.
  typedef struct packed {
    logic        pair;
    logic [15:0] unit0;
    logic [15:0] unit1;
    status_t     status;
    logic [15:0] count0;
    logic [15:0] count1;
    logic        last;
  } rec_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// File: sv/u2u_front.sv
// Front end of the decoder: sequence state, byte classification and
// result formation. Depends on u2u_pkg.
module u2u_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  input  logic          end_of_string,
  output logic          emit,
  output u2u_pkg::rec_t rec
);
  import u2u_pkg::*;

  logic [20:0] code_accumulator, code_accumulator_next;
  logic [1:0]  bytes_pending, bytes_pending_next;
  logic        error_latched, error_latched_next;
  logic [15:0] units_emitted, units_emitted_next;

  logic        bad;
  logic        done;
  logic [20:0] cp;
  logic [20:0] offset;
  logic [15:0] c1;
  logic [15:0] c2;

  always_comb begin
    bad = 1'b0;
    done = 1'b0;
    emit = 1'b0;
    rec = '0;
    rec.status = ST_UNIT;
    code_accumulator_next = code_accumulator;
    bytes_pending_next = bytes_pending;
    error_latched_next = error_latched;
    units_emitted_next = units_emitted;
    c1 = sat_inc(units_emitted);
    c2 = sat_inc(c1);
    cp = code_accumulator;
    offset = '0;

    if (error_latched) begin
      // Bytes after an error are dropped until the end mark.
      if (end_of_string) begin
        emit = 1'b1;
        rec.status = ST_END_ONLY;
        rec.count0 = units_emitted;
        rec.last = 1'b1;
        code_accumulator_next = '0;
        bytes_pending_next = '0;
        error_latched_next = 1'b0;
        units_emitted_next = '0;
      end
    end else begin
      if (bytes_pending == 2'd0) begin
        if (data_byte <= ASCII_MAX) begin
          code_accumulator_next = {13'd0, data_byte};
          done = 1'b1;
        end else if (data_byte <= CONT_MAX) begin
          bad = 1'b1;
        end else if (data_byte <= LEAD2_MAX) begin
          code_accumulator_next = {16'd0, data_byte[4:0]};
          bytes_pending_next = 2'd1;
        end else if (data_byte <= LEAD3_MAX) begin
          code_accumulator_next = {17'd0, data_byte[3:0]};
          bytes_pending_next = 2'd2;
        end else if (data_byte <= LEAD4_MAX) begin
          code_accumulator_next = {18'd0, data_byte[2:0]};
          bytes_pending_next = 2'd3;
        end else begin
          bad = 1'b1;
        end
      end else begin
        if (data_byte[7:6] != 2'b10) begin
          bad = 1'b1;
        end else begin
          code_accumulator_next = {code_accumulator[14:0], data_byte[5:0]};
          bytes_pending_next = bytes_pending - 2'd1;
          done = (bytes_pending == 2'd1);
        end
      end

      cp = code_accumulator_next;
      offset = cp - SUPP_BASE;

      if (done) begin
        if ((cp >= SURR_LOW && cp <= SURR_HIGH) || cp > CP_MAX) begin
          bad = 1'b1;
        end else if (cp <= BMP_MAX) begin
          emit = 1'b1;
          rec.unit0 = cp[15:0];
          rec.count0 = c1;
          rec.last = end_of_string;
          units_emitted_next = c1;
        end else begin
          emit = 1'b1;
          rec.pair = 1'b1;
          rec.unit0 = HIGH_BASE | {6'd0, offset[19:10]};
          rec.unit1 = LOW_BASE | {6'd0, offset[9:0]};
          rec.count0 = c1;
          rec.count1 = c2;
          rec.last = end_of_string;
          units_emitted_next = c2;
        end
        code_accumulator_next = '0;
      end else if (!bad && end_of_string) begin
        // The string ended inside a sequence.
        bad = 1'b1;
      end

      if (bad) begin
        emit = 1'b1;
        rec = '0;
        rec.status = ST_MALFORMED;
        rec.count0 = units_emitted;
        rec.last = end_of_string;
        code_accumulator_next = '0;
        bytes_pending_next = '0;
        units_emitted_next = units_emitted;
        if (end_of_string) begin
          units_emitted_next = '0;
        end else begin
          error_latched_next = 1'b1;
        end
      end else if (end_of_string) begin
        code_accumulator_next = '0;
        bytes_pending_next = '0;
        units_emitted_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_accumulator <= '0;
      bytes_pending <= '0;
      error_latched <= 1'b0;
      units_emitted <= '0;
    end else if (accept) begin
      code_accumulator <= code_accumulator_next;
      bytes_pending <= bytes_pending_next;
      error_latched <= error_latched_next;
      units_emitted <= units_emitted_next;
    end
  end

endmodule

// File: sv/u2u_fifo.sv
// Short queue between the front and back ends of the decoder.
// Depends on u2u_pkg for the entry type.
module u2u_fifo #(
  parameter int DEPTH = u2u_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  u2u_pkg::rec_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output u2u_pkg::rec_t rd_data,
  output logic          empty
);
  import u2u_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/u2u_back.sv
// Back end of the decoder: output register that splits surrogate pairs
// into two results. Depends on u2u_pkg.
module u2u_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  u2u_pkg::rec_t q_data,
  output logic          q_take,
  output logic [15:0]   code_unit,
  output logic [1:0]    status,
  output logic [15:0]   unit_count,
  output logic          last,
  output logic          empty,
  input  logic          pop
);
  import u2u_pkg::*;

  rec_t cur;
  logic valid;
  logic phase;
  logic finishing;

  assign finishing = valid && pop && (!cur.pair || phase);
  assign q_take = q_valid && (!valid || finishing);

  assign empty = !valid;
  assign code_unit = phase ? cur.unit1 : cur.unit0;
  assign unit_count = phase ? cur.count1 : cur.count0;
  assign status = cur.status;
  // The high surrogate of a pair is never the final result.
  assign last = (cur.pair && !phase) ? 1'b0 : cur.last;

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (q_take) begin
      valid <= 1'b1;
      phase <= 1'b0;
    end else if (finishing) begin
      valid <= 1'b0;
      phase <= 1'b0;
    end else if (valid && pop) begin
      phase <= 1'b1;
    end
  end

endmodule

// File: sv/utf8_to_utf16_decoder.sv
// UTF-8 to UTF-16 decoder, one byte per request.
// Usage:
//   Input: drive data_byte and end_of_string with push; the request is taken
//   at a clock edge where push is high and full is low. Bytes are accepted at
//   one per cycle while the internal queue has room.
//   Output: while empty is low, code_unit, status, unit_count and last show
//   the oldest result; pop takes it. status 0 is a code unit, 1 reports
//   malformed input (after which bytes are dropped up to the end mark) and 2
//   is the end mark that follows such an error.
//   A result is written into the queue at the edge that accepts the byte
//   causing it and is shown once it has passed into the output register.
//   Throughput: one byte per cycle in while full is low and one result per
//   cycle out while a result waits and pop is high; a supplementary code
//   point gives a surrogate pair, two results, which take two pops from the
//   single output register. When the receiver stalls, results collect in
//   the queue (FIFO_DEPTH entries plus the output register) and full rises
//   once the queue fills. Reset (rst, synchronous) clears the decode state,
//   the queue and empties the output register; empty is high afterwards.
// Depends on u2u_pkg, u2u_front, u2u_fifo, u2u_back.
module utf8_to_utf16_decoder #(
  parameter int FIFO_DEPTH = u2u_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] code_unit,
  output logic [1:0]  status,
  output logic [15:0] unit_count,
  output logic        last
);
  import u2u_pkg::*;

  logic accept;
  logic emit;
  rec_t front_rec;
  rec_t q_data;
  logic q_empty;
  logic q_take;

  assign accept = push && !full;

  u2u_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .data_byte     (data_byte),
    .end_of_string (end_of_string),
    .emit          (emit),
    .rec           (front_rec)
  );

  u2u_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && emit),
    .wr_data (front_rec),
    .full    (full),
    .rd_en   (q_take),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  u2u_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (!q_empty),
    .q_data     (q_data),
    .q_take     (q_take),
    .code_unit  (code_unit),
    .status     (status),
    .unit_count (unit_count),
    .last       (last),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// File: sv/u2u_checker.sv
// Port-level checks for the UTF-8 to UTF-16 decoder, bound to the top level.
// Depends on u2u_pkg.
module u2u_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] code_unit,
  input logic [1:0]  status,
  input logic [15:0] unit_count,
  input logic        last
);
  import u2u_pkg::*;

  // Reset leaves no result waiting and the input open.
  a_reset_empty: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result shown or input blocked right after reset");

  // Error reports carry no code unit.
  a_error_no_unit: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_UNIT) |-> (code_unit == 16'd0))
    else $error("error result carries a code unit");

  // The end mark after an error is always the final result of its string.
  a_end_only_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_END_ONLY) |-> last)
    else $error("end-only result without last");

  // A waiting result holds while it is not taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(code_unit) && $stable(status)
                          && $stable(unit_count) && $stable(last)))
    else $error("waiting result changed");

endmodule

bind utf8_to_utf16_decoder u2u_checker u_checker (.*);
